// ===== sv/dpgm_pkg.sv =====
`timescale 1ns / 1ps
package dpgm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int GATE_W      = 12;
    localparam int MOMENT_W    = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Gate numbers at or above this count are clamped to the last gate.
    localparam int MAX_GATES = 4096;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BASE         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RADAR_CONST_DB      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POWER_CORRECTION_DB = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_OFFSET_DB     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_SCALE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_SCALE         = 3'd5;

    // Angles in Q3.13 radians.
    localparam logic signed [16:0] PI_Q      = 17'sd25736;
    localparam logic signed [16:0] HALF_PI_Q = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q  = 17'sd51472;

    // 10log10(2) and 20log10(2) scaled by 2^16, ln(2) scaled by 2^16.
    localparam logic signed [19:0] K10_DB  = 20'sd197284;
    localparam logic signed [19:0] K20_DB  = 20'sd394568;
    localparam logic [15:0]        LN2_Q16 = 16'd45426;

    // Log ratio used for the spectrum width when the power sum is zero or the ratio is negative, Q32.
    localparam logic [39:0] WIDTH_FLOOR_Q32 = 40'd429497;

    localparam int CORDIC_STEPS = 14;
    localparam int ROOT_STEPS   = 24;
    localparam int LOG_STEPS    = 16;
    localparam int DIV_STEPS    = 32;
    localparam int WROOT_STEPS  = 20;

endpackage

// ===== sv/dpgm_gate_if.sv =====
`timescale 1ns / 1ps
interface dpgm_gate_if import dpgm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] first_i;
    logic signed [SAMPLE_W-1:0] first_q;
    logic signed [SAMPLE_W-1:0] first_power;
    logic signed [SAMPLE_W-1:0] second_i;
    logic signed [SAMPLE_W-1:0] second_q;
    logic signed [SAMPLE_W-1:0] second_power;
    logic [GATE_W-1:0]          gate_index;
    logic                       last_gate;

    modport source (
        output valid, first_i, first_q, first_power,
        output second_i, second_q, second_power, gate_index, last_gate,
        input  ready
    );
    modport sink (
        input  valid, first_i, first_q, first_power,
        input  second_i, second_q, second_power, gate_index, last_gate,
        output ready
    );
endinterface

// ===== sv/dpgm_moment_if.sv =====
`timescale 1ns / 1ps
interface dpgm_moment_if import dpgm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [MOMENT_W-1:0] velocity;
    logic [MOMENT_W-1:0]        spectrum_width;
    logic signed [MOMENT_W-1:0] reflectivity;
    logic signed [MOMENT_W-1:0] coherent_reflectivity;
    logic signed [MOMENT_W-1:0] coherent_power_ratio;
    logic signed [MOMENT_W-1:0] raw_power;
    logic                       end_of_ray;

    modport source (
        output valid, velocity, spectrum_width, reflectivity,
        output coherent_reflectivity, coherent_power_ratio, raw_power, end_of_ray,
        input  ready
    );
    modport sink (
        input  valid, velocity, spectrum_width, reflectivity,
        input  coherent_reflectivity, coherent_power_ratio, raw_power, end_of_ray,
        output ready
    );
endinterface

// ===== sv/dpgm_cfg_if.sv =====
`timescale 1ns / 1ps
interface dpgm_cfg_if import dpgm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/dual_pol_radar_gate_moments.sv =====
// Dual-polarization moment estimator: one range gate goes in per cycle while the output is not
// stalled, and one result comes out per gate, in order. A gate accepted at one clock edge is
// registered into the first stage and shows its result on the output from the last stage.
// The depth is set by the longest dependent chain: the 24-step magnitude square roots, the
// 16-step base-2 logarithm of the coherent power and the 20-step spectrum width root, each built
// as one pipeline stage per step, with the 32-step divider for the coherent power ratio running
// alongside. A stall on the output holds the whole pipeline in place, so ready on the input
// follows the output register: it is high whenever that register is empty or being taken.
// Configuration writes are always accepted and should be made only while no gate is in flight.
`timescale 1ns / 1ps
module dual_pol_radar_gate_moments import dpgm_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    dpgm_gate_if.sink            gates,
    dpgm_moment_if.source        moments,
    dpgm_cfg_if.sink             cfg
);

    localparam int ST_CORDIC_FIRST = 1;
    localparam int ST_PHASE        = ST_CORDIC_FIRST + CORDIC_STEPS;
    localparam int ST_DP           = ST_PHASE + 1;
    localparam int ST_VWRAP        = ST_DP + 1;
    localparam int ST_VMUL         = ST_VWRAP + 1;
    localparam int ST_VEL          = ST_VMUL + 1;
    localparam int ST_ROOT_FIRST   = 1;
    localparam int ST_CP           = ST_ROOT_FIRST + ROOT_STEPS;
    localparam int ST_LOG_INIT     = ST_CP + 1;
    localparam int ST_LOG_FIRST    = ST_LOG_INIT + 1;
    localparam int ST_LVAL         = ST_LOG_FIRST + LOG_STEPS;
    localparam int ST_DIV_FIRST    = ST_LOG_INIT + 1;
    localparam int ST_NCP          = ST_DIV_FIRST + DIV_STEPS;
    localparam int ST_DBMUL        = ST_LVAL + 1;
    localparam int ST_DB           = ST_DBMUL + 1;
    localparam int ST_RANGE        = ST_DB + 1;
    localparam int ST_CORR         = ST_RANGE + 1;
    localparam int ST_REFL         = ST_CORR + 1;
    localparam int ST_WROOT_FIRST  = ST_DB + 1;
    localparam int ST_SWMUL        = ST_WROOT_FIRST + WROOT_STEPS;
    localparam int ST_SW           = ST_SWMUL + 1;
    localparam int DEPTH           = ST_SW + 1;

    typedef struct packed {
        logic [15:0] window_base;
        logic [15:0] radar_const_db;
        logic [15:0] power_correction_db;
        logic [15:0] range_offset_db;
        logic [15:0] velocity_scale;
        logic [15:0] width_scale;
    } cfg_t;

    typedef struct packed {
        logic signed [25:0] x;
        logic signed [25:0] y;
        logic signed [16:0] z;
        logic               zero;
    } cordic_t;

    typedef struct packed {
        logic [47:0] rem;
        logic [47:0] res;
    } root_t;

    typedef struct packed {
        logic [4:0]  n;
        logic [30:0] m;
        logic [15:0] f;
    } log_t;

    typedef struct packed {
        logic signed [15:0] raw_power;
        logic               eor;
        logic [GATE_W-1:0]  gate;
        cordic_t            c1;
        cordic_t            c2;
        logic signed [15:0] v1;
        logic signed [18:0] dp;
        logic signed [19:0] vph;
        logic signed [37:0] vprod;
        logic signed [15:0] vel;
        root_t              r1;
        root_t              r2;
        logic signed [16:0] psum;
        logic [16:0]        mag;
        logic [24:0]        cp;
        log_t [2:0]         lg;
        logic [31:0]        dvd;
        logic [31:0]        quo;
        logic [16:0]        drem;
        logic signed [15:0] ncp;
        logic signed [22:0] lr;
        logic signed [22:0] lc;
        logic signed [22:0] lgt;
        logic signed [22:0] lw;
        logic signed [42:0] pr;
        logic signed [42:0] pc;
        logic signed [42:0] pg;
        logic [39:0]        w;
        logic signed [19:0] dbr;
        logic signed [19:0] dbc;
        logic signed [19:0] dbg;
        logic signed [19:0] rng;
        logic signed [20:0] corr;
        logic signed [15:0] refl;
        logic signed [15:0] crefl;
        root_t              wr;
        logic [35:0]        swp;
        logic [15:0]        sw;
    } pipe_t;

    function automatic logic signed [16:0] atan_entry(input int i);
        logic signed [16:0] r;
        unique case (i)
            0:       r = 17'sd6434;
            1:       r = 17'sd3798;
            2:       r = 17'sd2007;
            3:       r = 17'sd1019;
            4:       r = 17'sd511;
            5:       r = 17'sd256;
            6:       r = 17'sd128;
            7:       r = 17'sd64;
            8:       r = 17'sd32;
            9:       r = 17'sd16;
            10:      r = 17'sd8;
            11:      r = 17'sd4;
            12:      r = 17'sd2;
            13:      r = 17'sd1;
            default: r = 17'sd0;
        endcase
        return r;
    endfunction

    function automatic cordic_t cordic_init(input logic signed [15:0] re,
                                            input logic signed [15:0] im);
        cordic_t            r;
        logic signed [25:0] x;
        logic signed [25:0] y;
        x = {{2{re[15]}}, re, 8'd0};
        y = {{2{im[15]}}, im, 8'd0};
        r.zero = (re == 16'sd0) && (im == 16'sd0);
        r.x = x;
        r.y = y;
        r.z = 17'sd0;
        // Left half plane: rotate by a quarter turn first.
        if (x < 0) begin
            if (y >= 0) begin
                r.x = y;
                r.y = -x;
                r.z = HALF_PI_Q;
            end else begin
                r.x = -y;
                r.y = x;
                r.z = -HALF_PI_Q;
            end
        end
        return r;
    endfunction

    function automatic cordic_t cordic_step(input cordic_t a, input int i);
        cordic_t            r;
        logic signed [25:0] dx;
        logic signed [25:0] dy;
        dx = a.y >>> i;
        dy = a.x >>> i;
        r = a;
        if (a.y >= 0) begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + atan_entry(i);
        end else begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - atan_entry(i);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] phase_final(input cordic_t a);
        logic signed [16:0] z;
        if (a.zero) begin
            z = 17'sd0;
        end else if (a.z > PI_Q) begin
            z = PI_Q;
        end else if (a.z < -PI_Q) begin
            z = -PI_Q;
        end else begin
            z = a.z;
        end
        return z[15:0];
    endfunction

    function automatic root_t root_step(input root_t s, input int bpos);
        root_t       r;
        logic [48:0] trial;
        trial = {1'b0, s.res} + (49'd1 << bpos);
        if ({1'b0, s.rem} >= trial) begin
            r.rem = s.rem - trial[47:0];
            r.res = (s.res >> 1) + (48'd1 << bpos);
        end else begin
            r.rem = s.rem;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    function automatic log_t log_init(input logic [24:0] x);
        log_t       r;
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 25; i++) begin
            if (x[i]) begin
                n = 5'(i);
            end
        end
        r.n = n;
        r.m = 31'(x) << (5'd30 - n);
        r.f = 16'd0;
        return r;
    endfunction

    function automatic log_t log_step(input log_t l);
        log_t        r;
        logic [61:0] sq;
        logic [31:0] t;
        sq = l.m * l.m;
        t = sq[61:30];
        r.n = l.n;
        r.f = {l.f[14:0], t[31]};
        r.m = t[31] ? t[31:1] : t[30:0];
        return r;
    endfunction

    function automatic pipe_t stage_load(input logic signed [15:0] a1,
                                         input logic signed [15:0] b1,
                                         input logic signed [15:0] p1,
                                         input logic signed [15:0] a2,
                                         input logic signed [15:0] b2,
                                         input logic signed [15:0] p2,
                                         input logic [GATE_W-1:0]  gate,
                                         input logic               eor);
        pipe_t              o;
        logic signed [31:0] aa1;
        logic signed [31:0] bb1;
        logic signed [31:0] aa2;
        logic signed [31:0] bb2;
        logic [32:0]        sq1;
        logic [32:0]        sq2;
        o = '0;
        o.raw_power = p1;
        o.eor = eor;
        o.gate = (int'(gate) >= MAX_GATES) ? GATE_W'(MAX_GATES - 1) : gate;
        o.c1 = cordic_init(a1, b1);
        o.c2 = cordic_init(a2, b2);
        aa1 = a1 * a1;
        bb1 = b1 * b1;
        aa2 = a2 * a2;
        bb2 = b2 * b2;
        sq1 = {1'b0, aa1} + {1'b0, bb1};
        sq2 = {1'b0, aa2} + {1'b0, bb2};
        o.r1.rem = {sq1[31:0], 16'd0};
        o.r1.res = 48'd0;
        o.r2.rem = {sq2[31:0], 16'd0};
        o.r2.res = 48'd0;
        o.psum = 17'(p1) + 17'(p2);
        o.mag = o.psum[16] ? 17'(-o.psum) : 17'(o.psum);
        return o;
    endfunction

    function automatic pipe_t stage_step(input int k, input pipe_t s, input cfg_t c);
        pipe_t              o;
        logic signed [16:0] theta;
        logic signed [18:0] po;
        logic signed [18:0] upper;
        logic signed [18:0] dp;
        logic signed [19:0] v;
        logic signed [16:0] vs;
        logic signed [37:0] vr;
        logic [37:0]        wp;
        logic signed [21:0] rsum;
        logic signed [21:0] csum;
        logic [36:0]        swr;
        logic [17:0]        dr;
        o = s;

        // Phase of both sample sets, then the velocity.
        if (k >= ST_CORDIC_FIRST && k < ST_PHASE) begin
            o.c1 = cordic_step(s.c1, k - ST_CORDIC_FIRST);
            o.c2 = cordic_step(s.c2, k - ST_CORDIC_FIRST);
        end
        if (k == ST_PHASE) begin
            o.v1 = phase_final(s.c1);
            theta = 17'(phase_final(s.c1)) - 17'(phase_final(s.c2));
            if (theta > PI_Q) begin
                theta = theta - TWO_PI_Q;
            end
            if (theta < -PI_Q) begin
                theta = theta + TWO_PI_Q;
            end
            o.dp = 19'(theta >>> 1);
        end
        if (k == ST_DP) begin
            // Fold the half difference into the window that starts at the window base.
            po = 19'(signed'(c.window_base));
            upper = po + 19'(PI_Q);
            dp = s.dp;
            if (dp > upper) begin
                dp = dp - 19'(PI_Q);
            end
            if (dp < po) begin
                dp = dp + 19'(PI_Q);
            end
            o.dp = dp;
        end
        if (k == ST_VWRAP) begin
            v = 20'(s.v1) - 20'(s.dp);
            if (v < -20'(PI_Q)) begin
                v = v + 20'(TWO_PI_Q);
            end
            if (v > 20'(PI_Q)) begin
                v = v - 20'(TWO_PI_Q);
            end
            o.vph = v;
        end
        if (k == ST_VMUL) begin
            vs = signed'({1'b0, c.velocity_scale});
            o.vprod = s.vph * vs;
        end
        if (k == ST_VEL) begin
            vr = (s.vprod + 38'sd4096) >>> 13;
            if (vr > 38'sd32767) begin
                o.vel = 16'sh7FFF;
            end else if (vr < -38'sd32768) begin
                o.vel = 16'sh8000;
            end else begin
                o.vel = vr[15:0];
            end
        end

        // Magnitudes of both lag values, 8 fraction bits.
        if (k >= ST_ROOT_FIRST && k < ST_CP) begin
            o.r1 = root_step(s.r1, 46 - 2 * (k - ST_ROOT_FIRST));
            o.r2 = root_step(s.r2, 46 - 2 * (k - ST_ROOT_FIRST));
        end
        if (k == ST_CP) begin
            o.cp = {1'b0, s.r1.res[23:0]} + {1'b0, s.r2.res[23:0]};
        end

        // Logarithms of power sum, coherent power and gate; ratio division.
        if (k == ST_LOG_INIT) begin
            o.lg[0] = log_init(25'(s.mag));
            o.lg[1] = log_init(s.cp);
            o.lg[2] = log_init(25'(s.gate));
            o.dvd = {s.cp, 7'd0};
            o.quo = 32'd0;
            o.drem = 17'd0;
        end
        if (k >= ST_LOG_FIRST && k < ST_LVAL) begin
            o.lg[0] = log_step(s.lg[0]);
            o.lg[1] = log_step(s.lg[1]);
            o.lg[2] = log_step(s.lg[2]);
        end
        if (k >= ST_DIV_FIRST && k < ST_NCP) begin
            dr = {s.drem, s.dvd[31]};
            o.dvd = {s.dvd[30:0], 1'b0};
            if (dr >= {1'b0, s.mag}) begin
                o.drem = 17'(dr - {1'b0, s.mag});
                o.quo = {s.quo[30:0], 1'b1};
            end else begin
                o.drem = dr[16:0];
                o.quo = {s.quo[30:0], 1'b0};
            end
        end
        if (k == ST_NCP) begin
            if (s.psum == 17'sd0) begin
                o.ncp = 16'sh7FFF;
            end else if (s.quo >= 32'd32768) begin
                o.ncp = s.psum[16] ? 16'sh8000 : 16'sh7FFF;
            end else if (s.psum[16]) begin
                o.ncp = -signed'({1'b0, s.quo[14:0]});
            end else begin
                o.ncp = signed'({1'b0, s.quo[14:0]});
            end
        end

        // Decibel values and the log ratio for the width.
        if (k == ST_LVAL) begin
            o.lr = signed'({2'b00, s.lg[0].n, s.lg[0].f});
            o.lc = signed'({2'b00, s.lg[1].n, s.lg[1].f}) - 23'sd524288;
            o.lgt = signed'({2'b00, s.lg[2].n, s.lg[2].f});
            o.lw = signed'({2'b00, s.lg[0].n, s.lg[0].f})
                 - signed'({2'b00, s.lg[1].n, s.lg[1].f}) + 23'sd524288;
        end
        if (k == ST_DBMUL) begin
            o.pr = s.lr * K10_DB;
            o.pc = s.lc * K10_DB;
            o.pg = s.lgt * K20_DB;
            wp = s.lw[21:0] * LN2_Q16;
            if (s.mag == 17'd0 || s.lw < 0) begin
                o.w = WIDTH_FLOOR_Q32;
            end else begin
                o.w = {2'b00, wp};
            end
        end
        if (k == ST_DB) begin
            o.dbr = 20'((s.pr + 43'sd8388608) >>> 24);
            o.dbc = 20'((s.pc + 43'sd8388608) >>> 24);
            o.dbg = 20'((s.pg + 43'sd8388608) >>> 24);
            o.wr.rem = {8'd0, s.w};
            o.wr.res = 48'd0;
        end
        if (k == ST_RANGE) begin
            o.rng = (s.gate == '0) ? 20'sd0 : s.dbg + 20'(signed'(c.range_offset_db));
        end
        if (k == ST_CORR) begin
            o.corr = 21'(signed'(c.power_correction_db)) + 21'(signed'(c.radar_const_db))
                   + 21'(s.rng);
        end
        if (k == ST_REFL) begin
            rsum = 22'(s.dbr) + 22'(s.corr);
            csum = 22'(s.dbc) + 22'(s.corr);
            if (s.mag == 17'd0 || rsum < -22'sd32768) begin
                o.refl = 16'sh8000;
            end else if (rsum > 22'sd32767) begin
                o.refl = 16'sh7FFF;
            end else begin
                o.refl = rsum[15:0];
            end
            if (s.cp == 25'd0 || csum < -22'sd32768) begin
                o.crefl = 16'sh8000;
            end else if (csum > 22'sd32767) begin
                o.crefl = 16'sh7FFF;
            end else begin
                o.crefl = csum[15:0];
            end
        end

        // Spectrum width.
        if (k >= ST_WROOT_FIRST && k < ST_SWMUL) begin
            o.wr = root_step(s.wr, 38 - 2 * (k - ST_WROOT_FIRST));
        end
        if (k == ST_SWMUL) begin
            o.swp = s.wr.res[19:0] * c.width_scale;
        end
        if (k == ST_SW) begin
            swr = {1'b0, s.swp} + 37'd32768;
            if (s.cp == 25'd0 || swr[36:32] != 5'd0) begin
                o.sw = 16'hFFFF;
            end else begin
                o.sw = swr[31:16];
            end
        end
        return o;
    endfunction

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    pipe_t            stage_reg [DEPTH];
    pipe_t            stage_next [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             advance;
    logic             in_accept;

    assign advance   = !valid_reg[DEPTH-1] || moments.ready;
    assign in_accept = gates.valid && advance;
    assign gates.ready = advance;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WINDOW_BASE:         cfg_next.window_base = cfg.data;
                REG_RADAR_CONST_DB:      cfg_next.radar_const_db = cfg.data;
                REG_POWER_CORRECTION_DB: cfg_next.power_correction_db = cfg.data;
                REG_RANGE_OFFSET_DB:     cfg_next.range_offset_db = cfg.data;
                REG_VELOCITY_SCALE:      cfg_next.velocity_scale = cfg.data;
                REG_WIDTH_SCALE:         cfg_next.width_scale = cfg.data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{window_base: 16'd0, radar_const_db: 16'd0,
                         power_correction_db: 16'd0, range_offset_db: 16'd0,
                         velocity_scale: 16'd256, width_scale: 16'd256};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign stage_next[0] = stage_load(gates.first_i, gates.first_q, gates.first_power,
                                      gates.second_i, gates.second_q, gates.second_power,
                                      gates.gate_index, gates.last_gate);

    for (genvar g = 1; g < DEPTH; g++)
    begin : g_stage
        assign stage_next[g] = stage_step(g, stage_reg[g-1], cfg_reg);
    end

    assign valid_next = {valid_reg[DEPTH-2:0], in_accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign moments.valid                 = valid_reg[DEPTH-1];
    assign moments.velocity              = stage_reg[DEPTH-1].vel;
    assign moments.spectrum_width        = stage_reg[DEPTH-1].sw;
    assign moments.reflectivity          = stage_reg[DEPTH-1].refl;
    assign moments.coherent_reflectivity = stage_reg[DEPTH-1].crefl;
    assign moments.coherent_power_ratio  = stage_reg[DEPTH-1].ncp;
    assign moments.raw_power             = stage_reg[DEPTH-1].raw_power;
    assign moments.end_of_ray            = stage_reg[DEPTH-1].eor;

endmodule

// ===== sv/dpgm_checker.sv =====
`timescale 1ns / 1ps
module dpgm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [96:0] out_data
);

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // The input side moves exactly when the output register can move.
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output register state");

    // Nothing comes out right after reset, since the pipeline starts empty.
    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result shown right after reset");

    // A gate offered while the output is empty is taken in that cycle.
    a_no_idle_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !out_valid |-> in_ready)
        else $error("gate refused while output register empty");

endmodule

bind dual_pol_radar_gate_moments dpgm_checker u_dpgm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (gates.valid),
    .in_ready  (gates.ready),
    .out_valid (moments.valid),
    .out_ready (moments.ready),
    .out_data  ({moments.velocity, moments.spectrum_width, moments.reflectivity,
                 moments.coherent_reflectivity, moments.coherent_power_ratio,
                 moments.raw_power, moments.end_of_ray})
);

// ===== bench/dual_pol_radar_gate_moments_tb.sv =====
`timescale 1ns / 1ps
module dual_pol_radar_gate_moments_tb;
    import dpgm_pkg::*;

    typedef struct {
        logic signed [15:0] vel;
        logic [15:0]        sw;
        logic signed [15:0] refl;
        logic signed [15:0] crefl;
        logic signed [15:0] ncp;
        logic signed [15:0] rawp;
        logic               eor;
    } moment_t;

    localparam longint ATAN_STEP [0:13] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32,
                                           16, 8, 4, 2, 1};

    logic clk;
    logic rst_n;
    longint cycle_count;
    int error_count;
    int src_idle_pct;
    int snk_stall_pct;
    moment_t expected_moments[$];

    logic signed [15:0] cur_window_base;
    logic signed [15:0] cur_radar_const;
    logic signed [15:0] cur_power_corr;
    logic signed [15:0] cur_range_offset;
    logic [15:0]        cur_vel_scale;
    logic [15:0]        cur_width_scale;

    dpgm_gate_if   gates ();
    dpgm_moment_if moments ();
    dpgm_cfg_if    cfg ();

    dual_pol_radar_gate_moments dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .gates   (gates),
        .moments (moments),
        .cfg     (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 2000000)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic longint shr_arith(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint cordic_phase(longint re, longint im);
        longint x, y, z, t, dx, dy;
        x = re * 256;
        y = im * 256;
        z = 0;
        if (re == 0 && im == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = HALF_PI_Q;
            end
            else
            begin
                x = -y; y = t; z = -HALF_PI_Q;
            end
        end
        for (int k = 0; k < 14; k++)
        begin
            dx = shr_arith(y, k);
            dy = shr_arith(x, k);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ATAN_STEP[k];
            end
            else
            begin
                x -= dx; y += dy; z -= ATAN_STEP[k];
            end
        end
        return clamp(z, -PI_Q, PI_Q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint log2_q16(longint unsigned x);
        int n;
        longint unsigned m;
        longint fr;
        n = 63;
        fr = 0;
        while (x[n] == 1'b0)
            n--;
        m = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            fr <<= 1;
            if (m >= (64'd1 << 31))
            begin
                m >>= 1;
                fr |= 1;
            end
        end
        return longint'(n) * 65536 + fr;
    endfunction

    function automatic longint to_db(longint unsigned x, int fbits, longint k);
        longint l;
        l = log2_q16(x) - longint'(fbits) * 65536;
        return shr_arith(l * k + (64'sd1 <<< 23), 24);
    endfunction

    function automatic moment_t predict_moments(longint a, longint b, longint p,
                                                longint a2, longint b2, longint p2,
                                                longint unsigned gate, logic last);
        moment_t r;
        longint po, v1, v2, theta, dp, v, range, corr, psum, l, q;
        longint unsigned cp, mag, w, sw;
        po = cur_window_base;
        v1 = cordic_phase(a, b);
        v2 = cordic_phase(a2, b2);
        theta = v1 - v2;
        if (theta > PI_Q) theta -= TWO_PI_Q;
        if (theta < -PI_Q) theta += TWO_PI_Q;
        dp = shr_arith(theta, 1);
        if (dp > po + PI_Q) dp -= PI_Q;
        if (dp < po) dp += PI_Q;
        v = v1 - dp;
        if (v < -PI_Q) v += TWO_PI_Q;
        if (v > PI_Q) v -= TWO_PI_Q;
        r.vel = 16'(clamp(shr_arith(v * longint'(cur_vel_scale) + 4096, 13), -32768, 32767));

        cp = int_sqrt(longint'(a * a + b * b) << 16) + int_sqrt(longint'(a2 * a2 + b2 * b2) << 16);
        psum = p + p2;
        mag = psum < 0 ? -psum : psum;
        if (gate >= MAX_GATES)
            gate = MAX_GATES - 1;
        range = (gate == 0) ? 0 : to_db(gate, 0, K20_DB) + longint'(cur_range_offset);
        corr = longint'(cur_power_corr) + longint'(cur_radar_const) + range;
        r.refl = 16'((mag == 0) ? -32768
                                : clamp(to_db(mag, 0, K10_DB) + corr, -32768, 32767));
        r.crefl = 16'((cp == 0) ? -32768
                                : clamp(to_db(cp, 8, K10_DB) + corr, -32768, 32767));
        if (cp == 0)
            sw = 65535;
        else
        begin
            w = WIDTH_FLOOR_Q32;
            if (mag != 0)
            begin
                l = log2_q16(mag << 8) - log2_q16(cp);
                if (l >= 0)
                    w = longint'(l) * LN2_Q16;
            end
            sw = (int_sqrt(w) * cur_width_scale + 32768) >> 16;
            if (sw > 65535) sw = 65535;
        end
        r.sw = sw[15:0];
        if (psum == 0)
            r.ncp = 16'sd32767;
        else
        begin
            q = longint'((cp << 7) / mag);
            r.ncp = 16'(clamp(psum < 0 ? -q : q, -32768, 32767));
        end
        r.rawp = 16'(p);
        r.eor = last;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Ready is redrawn each cycle; the result is read at the edge, before the registers update.
    initial
    begin
        moment_t e;
        moments.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (moments.valid === 1'b1 && moments.ready === 1'b1)
            begin
                if (expected_moments.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    e = expected_moments.pop_front();
                    if (moments.velocity !== e.vel)
                        report_mismatch("velocity", moments.velocity, e.vel);
                    if (moments.spectrum_width !== e.sw)
                        report_mismatch("spectrum_width", moments.spectrum_width, e.sw);
                    if (moments.reflectivity !== e.refl)
                        report_mismatch("reflectivity", moments.reflectivity, e.refl);
                    if (moments.coherent_reflectivity !== e.crefl)
                        report_mismatch("coherent_reflectivity",
                                        moments.coherent_reflectivity, e.crefl);
                    if (moments.coherent_power_ratio !== e.ncp)
                        report_mismatch("coherent_power_ratio",
                                        moments.coherent_power_ratio, e.ncp);
                    if (moments.raw_power !== e.rawp)
                        report_mismatch("raw_power", moments.raw_power, e.rawp);
                    if (moments.end_of_ray !== e.eor)
                        report_mismatch("end_of_ray", moments.end_of_ray, e.eor);
                end
            end
            moments.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_gate(logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] p, logic signed [15:0] a2,
                             logic signed [15:0] b2, logic signed [15:0] p2,
                             logic [11:0] gate, logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            gates.valid <= 1'b0;
            @(posedge clk);
        end
        gates.valid        <= 1'b1;
        gates.first_i      <= a;
        gates.first_q      <= b;
        gates.first_power  <= p;
        gates.second_i     <= a2;
        gates.second_q     <= b2;
        gates.second_power <= p2;
        gates.gate_index   <= gate;
        gates.last_gate    <= last;
        expected_moments.push_back(predict_moments(a, b, p, a2, b2, p2, gate, last));
        do
            @(posedge clk);
        while (gates.ready !== 1'b1);
    endtask

    // Called right after an accepting edge, so valid drops before the next edge.
    task automatic drain_pipeline();
        gates.valid <= 1'b0;
        while (expected_moments.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        case (idx)
            REG_WINDOW_BASE:         cur_window_base = value;
            REG_RADAR_CONST_DB:      cur_radar_const = value;
            REG_POWER_CORRECTION_DB: cur_power_corr = value;
            REG_RANGE_OFFSET_DB:     cur_range_offset = value;
            REG_VELOCITY_SCALE:      cur_vel_scale = value;
            REG_WIDTH_SCALE:         cur_width_scale = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_settings(logic [15:0] po, logic [15:0] rc, logic [15:0] pc,
                                 logic [15:0] ro, logic [15:0] vs, logic [15:0] ws);
        write_register(REG_WINDOW_BASE, po);
        write_register(REG_RADAR_CONST_DB, rc);
        write_register(REG_POWER_CORRECTION_DB, pc);
        write_register(REG_RANGE_OFFSET_DB, ro);
        write_register(REG_VELOCITY_SCALE, vs);
        write_register(REG_WIDTH_SCALE, ws);
    endtask

    task automatic test_directed_gates();
        send_gate(0, 0, 0, 0, 0, 0, 0, 0);
        send_gate(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 12'hfff, 1);
        send_gate(-32768, -32768, -32768, -32768, -32768, -32768, 1, 0);
        send_gate(-32768, 0, 100, 32767, 0, 100, 2, 0);
        send_gate(-32768, 1, 500, -32768, -1, 500, 3, 1);
        send_gate(0, 0, 1000, 0, 0, -1000, 4, 0);
        send_gate(100, 50, 0, 100, 50, 0, 5, 0);
        send_gate(0, 0, 300, 0, 0, 200, 6, 0);
        send_gate(30000, 30000, 1, 30000, 30000, 0, 7, 0);
        send_gate(1, 0, -5, 0, 1, -6, 4000, 1);
        send_gate(0, -32768, 32767, 0, 32767, 32767, 0, 0);
        send_gate(-1, 0, 2, 1, 0, 3, 12'h800, 0);
    endtask

    task automatic test_random_gates(int count);
        logic [15:0] v [0:5];
        for (int n = 0; n < count; n++)
        begin
            for (int j = 0; j < 6; j++)
            begin
                case ($urandom_range(3))
                    0: v[j] = 16'($urandom);
                    1: v[j] = 16'($urandom_range(255) - 128);
                    2: v[j] = $urandom_range(1) ? 16'(16'h7fff - $urandom_range(3))
                                                : 16'(16'h8000 + $urandom_range(3));
                    default: v[j] = 16'($urandom_range(4095));
                endcase
            end
            if ($urandom_range(15) == 0)
                v[5] = -v[2];
            send_gate(v[0], v[1], v[2], v[3], v[4], v[5],
                      $urandom_range(7) == 0 ? 12'($urandom_range(3)) : 12'($urandom),
                      1'($urandom_range(1)));
        end
    endtask

    task automatic run_idle_phases(int count);
        src_idle_pct = 0;  snk_stall_pct = 0;  test_random_gates(count);
        src_idle_pct = 62; snk_stall_pct = 0;  test_random_gates(count);
        src_idle_pct = 0;  snk_stall_pct = 62; test_random_gates(count);
        src_idle_pct = 33; snk_stall_pct = 33; test_random_gates(count);
        src_idle_pct = 0;  snk_stall_pct = 0;
        drain_pipeline();
    endtask

    initial
    begin
        error_count = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        cur_window_base = 0;
        cur_radar_const = 0;
        cur_power_corr = 0;
        cur_range_offset = 0;
        cur_vel_scale = 256;
        cur_width_scale = 256;
        rst_n <= 1'b0;
        gates.valid <= 1'b0;
        gates.first_i <= '0;
        gates.first_q <= '0;
        gates.first_power <= '0;
        gates.second_i <= '0;
        gates.second_q <= '0;
        gates.second_power <= '0;
        gates.gate_index <= '0;
        gates.last_gate <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_gates();
        drain_pipeline();
        run_idle_phases(60);

        load_settings(16'(-25736), 16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'hffff);
        test_directed_gates();
        run_idle_phases(60);

        load_settings(16'd25736, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
        test_directed_gates();
        run_idle_phases(60);

        // Offsets outside the window plus an index that maps to no register.
        load_settings(16'h7fff, 16'd1000, 16'(-2000), 16'd500, 16'd1234, 16'd4000);
        write_register(3'd7, 16'hffff);
        run_idle_phases(60);

        load_settings(16'h8000, 16'(-500), 16'd300, 16'd0, 16'd256, 16'd256);
        run_idle_phases(60);

        for (int s = 0; s < 2; s++)
        begin
            load_settings(16'($urandom_range(51472) - 25736), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom));
            run_idle_phases(30);
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
